// ===== design/afp_pkg.sv =====
// shared constants, command and status types for the ascii hex frame parser
`default_nettype none

package afp_pkg;

  localparam int MAX_BODY    = 52;
  localparam int MAX_PAYLOAD = 48;
  localparam int POS_W       = $clog2(MAX_BODY);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W       = 8;
  localparam int MIN_BODY    = 5;
  localparam int COLON_POS   = 3;
  localparam int PAY_OFFSET  = 4;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  // frame register operation applied with an accepted byte or with the last payload byte
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LEN_HI,
    OP_LEN_LO,
    OP_LEN_SEP,
    OP_BODY,
    OP_CHK_HI,
    OP_CHK_LO
  } op_t;

  // kind of result placed in the output register
  typedef enum logic [2:0] {
    RES_NONE,
    RES_PROGRESS,
    RES_ERROR,
    RES_MSG_EMPTY,
    RES_MSG_START,
    RES_PAYLOAD
  } res_t;

  typedef struct packed {
    logic take;
    op_t  op;
    res_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_at;
    logic is_colon;
    logic is_nl;
    logic is_hex;
    logic body_ok;
    logic body_done;
    logic frame_ok;
    logic pay_empty;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

  // upper-case hex digit: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/afp_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module afp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/afp_datapath.sv =====
// frame registers, body store, counters and output register
`default_nettype none

module afp_datapath
  import afp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output      dp_stat_t    stat,
  input  wire logic [7:0]  rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  status,
  output      logic [23:0] message_type,
  output      logic [7:0]  payload_byte,
  output      logic        payload_valid,
  output      logic        payload_last,
  output      logic [31:0] bytes_seen,
  output      logic [31:0] messages_accepted,
  output      logic [31:0] errors_seen
);

  logic [LEN_W-1:0] body_length;
  logic [POS_W-1:0] body_position;
  logic [3:0]       check_high;
  logic [7:0]       check_received;
  logic [7:0]       running_xor;
  logic             zero_seen;
  logic [7:0]       type0, type1, type2;
  logic             colon3;
  logic             pay_stop;
  logic [CNT_W-1:0] pay_count;
  logic [CNT_W-1:0] emit_idx;
  logic [31:0]      byte_counter, message_counter, error_counter;

  logic [4:0]       hex;
  logic [7:0]       ram_rdata;
  logic [POS_W-1:0] ram_raddr;
  logic             ram_we;
  logic [23:0]      type_word;
  logic             out_free;

  assign hex       = hex_decode(rx_byte);
  assign ram_we    = cmd.take && (cmd.op == OP_BODY);
  assign ram_raddr = POS_W'(PAY_OFFSET) + POS_W'(emit_idx);
  assign out_free  = !out_valid || !out_stall;

  // type bytes from the first zero byte on read zero
  assign type_word = {type0,
                      (type0 == 8'd0) ? 8'd0 : type1,
                      (type0 == 8'd0 || type1 == 8'd0) ? 8'd0 : type2};

  assign stat.is_cr     = (rx_byte == CH_CR);
  assign stat.is_at     = (rx_byte == CH_AT);
  assign stat.is_colon  = (rx_byte == CH_COLON);
  assign stat.is_nl     = (rx_byte == CH_NL);
  assign stat.is_hex    = hex[4];
  assign stat.body_ok   = (body_position < POS_W'(MAX_BODY)) &&
                          (LEN_W'(body_position) < body_length);
  assign stat.body_done = (LEN_W'(body_position) + LEN_W'(1) == body_length);
  assign stat.frame_ok  = (running_xor == check_received) &&
                          (body_length >= LEN_W'(MIN_BODY)) &&
                          (LEN_W'(body_position) == body_length) && colon3;
  assign stat.pay_empty = (pay_count == '0);
  assign stat.emit_last = (emit_idx + CNT_W'(1) == pay_count);
  assign stat.out_free  = out_free;

  afp_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BODY)
  ) u_body_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(body_position),
    .wdata(rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      body_length    <= '0;
      body_position  <= '0;
      check_high     <= '0;
      check_received <= '0;
      running_xor    <= '0;
      zero_seen      <= 1'b0;
      colon3         <= 1'b0;
      pay_stop       <= 1'b0;
      pay_count      <= '0;
    end else if (cmd.op == OP_CLEAR && (cmd.take || cmd.res == RES_PAYLOAD)) begin
      body_length    <= '0;
      body_position  <= '0;
      check_high     <= '0;
      check_received <= '0;
      running_xor    <= '0;
      zero_seen      <= 1'b0;
      colon3         <= 1'b0;
      pay_stop       <= 1'b0;
      pay_count      <= '0;
    end else if (cmd.take) begin
      case (cmd.op)
        OP_LEN_HI: begin
          body_length <= {hex[3:0], 4'd0};
          running_xor <= running_xor ^ rx_byte;
        end
        OP_LEN_LO: begin
          body_length <= body_length | LEN_W'(hex[3:0]);
          running_xor <= running_xor ^ rx_byte;
        end
        OP_LEN_SEP: begin
          running_xor <= running_xor ^ rx_byte;
        end
        OP_BODY: begin
          body_position <= body_position + POS_W'(1);
          if (rx_byte == 8'd0) begin
            zero_seen <= 1'b1;
          end else if (!zero_seen) begin
            running_xor <= running_xor ^ rx_byte;
          end
          if (body_position == POS_W'(COLON_POS)) begin
            colon3 <= (rx_byte == CH_COLON);
          end
          // payload runs from offset 4 up to the first zero byte there
          if (body_position >= POS_W'(PAY_OFFSET) && !pay_stop) begin
            if (rx_byte == 8'd0) begin
              pay_stop <= 1'b1;
            end else if (pay_count < CNT_W'(MAX_PAYLOAD)) begin
              pay_count <= pay_count + CNT_W'(1);
            end
          end
        end
        OP_CHK_HI: begin
          check_high <= hex[3:0];
        end
        OP_CHK_LO: begin
          check_received <= {check_high, hex[3:0]};
        end
        default: begin
        end
      endcase
    end
  end

  // type bytes, only read after a full body
  always_ff @(posedge clk) begin
    if (cmd.take && cmd.op == OP_BODY) begin
      if (body_position == POS_W'(0)) type0 <= rx_byte;
      if (body_position == POS_W'(1)) type1 <= rx_byte;
      if (body_position == POS_W'(2)) type2 <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (cmd.res == RES_MSG_START) begin
      emit_idx <= '0;
    end else if (cmd.res == RES_PAYLOAD) begin
      emit_idx <= emit_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter    <= '0;
      message_counter <= '0;
      error_counter   <= '0;
    end else begin
      if (cmd.take) begin
        byte_counter <= byte_counter + 32'd1;
      end
      if (cmd.res == RES_ERROR) begin
        error_counter <= error_counter + 32'd1;
      end
      if (cmd.res inside {RES_MSG_EMPTY, RES_MSG_START}) begin
        message_counter <= message_counter + 32'd1;
      end
    end
  end

  // output register: counters stay put while a transaction waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(cmd.res inside {RES_NONE, RES_MSG_START})) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_PROGRESS, RES_ERROR: begin
        status        <= (cmd.res == RES_ERROR) ? ST_ERROR : ST_PROGRESS;
        message_type  <= '0;
        payload_byte  <= '0;
        payload_valid <= 1'b0;
        payload_last  <= 1'b1;
      end
      RES_MSG_EMPTY: begin
        status        <= ST_READY;
        message_type  <= type_word;
        payload_byte  <= '0;
        payload_valid <= 1'b0;
        payload_last  <= 1'b1;
      end
      RES_PAYLOAD: begin
        status        <= ST_READY;
        message_type  <= type_word;
        payload_byte  <= ram_rdata;
        payload_valid <= 1'b1;
        payload_last  <= stat.emit_last;
      end
      default: begin
      end
    endcase
  end

  assign bytes_seen        = byte_counter;
  assign messages_accepted = message_counter;
  assign errors_seen       = error_counter;

`ifndef NO_ASSERTIONS
  a_pay_count_bound: assert property (@(posedge clk) disable iff (rst)
    pay_count <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count above limit");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.res != RES_NONE && cmd.res != RES_MSG_START) |-> out_free)
    else $error("output register overwritten");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.res == RES_PAYLOAD) |-> (emit_idx < pay_count))
    else $error("payload read beyond count");

  a_error_counted: assert property (@(posedge clk) disable iff (rst)
    (cmd.res == RES_ERROR) |=> (out_valid && status == ST_ERROR &&
                                errors_seen == $past(errors_seen) + 32'd1))
    else $error("error transaction not counted");
`endif

endmodule

`default_nettype wire

// ===== design/afp_ctrl.sv =====
// frame parse and payload emission state machine
`default_nettype none

module afp_ctrl
  import afp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_stall,
  input  wire dp_stat_t stat,
  output      dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_HI,
    S_LEN_LO,
    S_LEN_SEP,
    S_BODY,
    S_CHK_SEP,
    S_CHK_HI,
    S_CHK_LO,
    S_END,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t state, state_next;
  logic   parsing;
  logic   take;
  logic   err;

  assign parsing  = !(state inside {S_EMIT_RD, S_EMIT_WR});
  assign in_stall = !(parsing && stat.out_free);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd.take   = take;
    cmd.op     = OP_NONE;
    cmd.res    = RES_NONE;
    err        = 1'b0;
    if (take) begin
      cmd.res = RES_PROGRESS;
      if (!stat.is_cr) begin
        case (state)
          S_IDLE: begin
            if (stat.is_at) begin
              cmd.op     = OP_CLEAR;
              state_next = S_LEN_HI;
            end
          end
          S_LEN_HI: begin
            if (stat.is_hex) begin
              cmd.op     = OP_LEN_HI;
              state_next = S_LEN_LO;
            end else begin
              err = 1'b1;
            end
          end
          S_LEN_LO: begin
            if (stat.is_hex) begin
              cmd.op     = OP_LEN_LO;
              state_next = S_LEN_SEP;
            end else begin
              err = 1'b1;
            end
          end
          S_LEN_SEP: begin
            if (stat.is_colon) begin
              cmd.op     = OP_LEN_SEP;
              state_next = S_BODY;
            end else begin
              err = 1'b1;
            end
          end
          S_BODY: begin
            if (stat.body_ok) begin
              cmd.op = OP_BODY;
              if (stat.body_done) state_next = S_CHK_SEP;
            end else begin
              err = 1'b1;
            end
          end
          S_CHK_SEP: begin
            if (stat.is_colon) state_next = S_CHK_HI;
            else err = 1'b1;
          end
          S_CHK_HI: begin
            if (stat.is_hex) begin
              cmd.op     = OP_CHK_HI;
              state_next = S_CHK_LO;
            end else begin
              err = 1'b1;
            end
          end
          S_CHK_LO: begin
            if (stat.is_hex) begin
              cmd.op     = OP_CHK_LO;
              state_next = S_END;
            end else begin
              err = 1'b1;
            end
          end
          S_END: begin
            if (stat.is_nl && stat.frame_ok) begin
              if (stat.pay_empty) begin
                cmd.res    = RES_MSG_EMPTY;
                cmd.op     = OP_CLEAR;
                state_next = S_IDLE;
              end else begin
                cmd.res    = RES_MSG_START;
                state_next = S_EMIT_RD;
              end
            end else begin
              err = 1'b1;
            end
          end
          default: begin
            cmd.op     = OP_CLEAR;
            state_next = S_IDLE;
          end
        endcase
      end
      // an offending '@' opens a new frame
      if (err) begin
        cmd.res    = RES_ERROR;
        cmd.op     = OP_CLEAR;
        state_next = stat.is_at ? S_LEN_HI : S_IDLE;
      end
    end else begin
      case (state)
        S_EMIT_RD: begin
          state_next = S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (stat.out_free) begin
            cmd.res = RES_PAYLOAD;
            if (stat.emit_last) begin
              cmd.op     = OP_CLEAR;
              state_next = S_IDLE;
            end else begin
              state_next = S_EMIT_RD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_while_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_WR) |-> !cmd.take)
    else $error("byte taken during payload emission");

  a_emit_follows_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.res == RES_MSG_START) |=> (state == S_EMIT_RD))
    else $error("message start without emission");
`endif

endmodule

`default_nettype wire

// ===== design/ascii_hex_frame_parser_unit.sv =====
// Throughput: one input byte per cycle is accepted while the output register is free
// and no payload is being emitted. A progress or error result is in the output register
// in the cycle after its byte is taken. For a valid frame, each payload byte is read from
// the body store in S_EMIT_RD and loaded from S_EMIT_WR when the output is free.
// Reset (rst, synchronous) returns the parser to waiting for start and clears the
// counters; the body store is not cleared.
`default_nettype none

module ascii_hex_frame_parser_unit
  import afp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  status,
  output      logic [23:0] message_type,
  output      logic [7:0]  payload_byte,
  output      logic        payload_valid,
  output      logic        payload_last,
  output      logic [31:0] bytes_seen,
  output      logic [31:0] messages_accepted,
  output      logic [31:0] errors_seen
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  afp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  afp_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .message_type     (message_type),
    .payload_byte     (payload_byte),
    .payload_valid    (payload_valid),
    .payload_last     (payload_last),
    .bytes_seen       (bytes_seen),
    .messages_accepted(messages_accepted),
    .errors_seen      (errors_seen)
  );

endmodule

`default_nettype wire
